// ===== rtl/irw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irw_pkg
// Types, constants and calibration tables for the infrared range to world
// point converter.
// ----------------------------------------------------------------------------
package irw_pkg;

  // raw sample width at the port, normalized to SAMPLE_BITS inside
  localparam int ADC_BITS    = 10;
  localparam int SAMPLE_BITS = 10;
  localparam int ADC_SHR     = (ADC_BITS >= SAMPLE_BITS) ? ADC_BITS - SAMPLE_BITS : 0;
  localparam int ADC_SHL     = (ADC_BITS < SAMPLE_BITS) ? SAMPLE_BITS - ADC_BITS : 0;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_SENSOR_TYPE = 3'd0,
    REG_MOUNT_X     = 3'd1,
    REG_MOUNT_Y     = 3'd2,
    REG_MOUNT_COS   = 3'd3,
    REG_MOUNT_SIN   = 3'd4,
    REG_WALL_LIMIT  = 3'd5
  } reg_idx_t;

  localparam logic [15:0] MOUNT_COS_RST  = 16'd16384;
  localparam logic [15:0] WALL_LIMIT_RST = 16'd22938;

  // distance limits and fixed answers outside the calibrated span
  localparam logic [15:0] DIST_MIN       = 16'd2621;
  localparam logic [15:0] DIST_MAX       = 16'd52429;
  localparam logic [15:0] LONG_NEAR_D    = 16'd52429;
  localparam logic [15:0] LONG_FAR_D     = 16'd6554;
  localparam logic [15:0] SHORT_NEAR_D   = 16'd19661;
  localparam logic [15:0] SHORT_FAR_D    = 16'd2621;
  localparam logic [9:0]  LONG_LO        = 10'd124;
  localparam logic [9:0]  LONG_HI        = 10'd927;
  localparam logic [9:0]  SHORT_LO       = 10'd96;
  localparam logic [9:0]  SHORT_HI       = 10'd853;

  // payload of one input transaction
  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic signed [31:0]  robot_x;
    logic signed [31:0]  robot_y;
    logic signed [15:0]  robot_sin;
    logic signed [15:0]  robot_cos;
  } in_t;

  // payload of one result transaction
  typedef struct packed {
    logic [15:0]        range_m;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] wall_x;
    logic signed [31:0] wall_y;
  } out_t;

  // robot pose carried down the pipeline
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [15:0] rs;
    logic signed [15:0] rc;
  } pose_t;

  // quadratic coefficients, 40 fraction bits
  typedef struct packed {
    logic signed [25:0] a;
    logic signed [34:0] b;
    logic signed [41:0] c;
  } coef_t;

  // upper breakpoint of each segment
  function automatic logic [9:0] seg_bound(input logic styp, input logic [1:0] seg);
    logic [9:0] bp;
    unique case ({styp, seg})
      3'b000:  bp = 10'd233;
      3'b001:  bp = 10'd334;
      3'b010:  bp = 10'd508;
      3'b011:  bp = 10'd853;
      3'b100:  bp = 10'd124;
      3'b101:  bp = 10'd334;
      3'b110:  bp = 10'd543;
      3'b111:  bp = 10'd853;
    endcase
    return bp;
  endfunction

  // segment coefficients for both sensor tables
  function automatic coef_t coef_lookup(input logic styp, input logic [1:0] seg);
    coef_t cf;
    unique case ({styp, seg})
      3'b000: begin
        cf.a = 26'sd21990233;  cf.b = -35'sd11984676743; cf.c = 42'sd2027389490456;
      end
      3'b001: begin
        cf.a = 26'sd3298535;   cf.b = -35'sd3628388372;  cf.c = 42'sd1093134460335;
      end
      3'b010: begin
        cf.a = -26'sd439805;   cf.b = -35'sd219902326;   cf.c = 42'sd402080962743;
      end
      3'b011: begin
        cf.a = 26'sd219902;    cf.b = -35'sd549755814;   cf.c = 42'sd369545858096;
      end
      3'b100: begin
        cf.a = -26'sd21990233; cf.b = 35'sd1649267442;   cf.c = 42'sd515561002264;
      end
      3'b101: begin
        cf.a = 26'sd3298535;   cf.b = -35'sd2418925581;  cf.c = 42'sd579772481326;
      end
      3'b110: begin
        cf.a = 26'sd549756;    cf.b = -35'sd769658139;   cf.c = 42'sd327544513914;
      end
      3'b111: begin
        cf.a = 26'sd76966;     cf.b = -35'sd219902326;   cf.c = 42'sd171963618584;
      end
    endcase
    return cf;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ir_range_to_world_point.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_range_to_world_point
// Turns one infrared range sample plus robot pose into a clamped distance,
// the world hit point and the world point at the wall-limited distance.
//
// Usage:
// - input channel (in_valid/in_ready/in_data): one sample and pose per
//   transaction; output channel (out_valid/out_ready/out_data): one result
//   per input transaction, in order
// - APB-style port: six registers at byte addresses 0,4,..,20, pready tied
//   high, registers read back; write them only while the pipeline is empty
// - nine register stages from input acceptance to out_valid: table lookup
//   and square, products, sum, clamp, mount products, mount offset, rotation
//   products, rotation rounding, translate/saturate
// - throughput: one transaction per cycle while out_ready is high; each stage
//   holds one item, has its own valid bit and advances whenever it is empty
//   or the next stage moves, so a stalled receiver only fills the bubbles in
//   front of it and in_ready drops once all nine stages hold an item
// - reset clears all stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module ir_range_to_world_point (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire irw_pkg::in_t                 in_data,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output irw_pkg::out_t                     out_data,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [irw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [irw_pkg::PDATA_W-1:0]  pwdata,
  output logic [irw_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int NumStg = 9;
  localparam int SmpW   = irw_pkg::SAMPLE_BITS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic               styp_r;
  logic signed [17:0] mnt_x_r;
  logic signed [17:0] mnt_y_r;
  logic signed [15:0] mnt_cos_r;
  logic signed [15:0] mnt_sin_r;
  logic [15:0]        wall_r;
  logic               cfg_wr;
  irw_pkg::reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = irw_pkg::reg_idx_t'(paddr[irw_pkg::PADDR_W-1:2]);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      styp_r    <= 1'b0;
      mnt_x_r   <= '0;
      mnt_y_r   <= '0;
      mnt_cos_r <= irw_pkg::MOUNT_COS_RST;
      mnt_sin_r <= '0;
      wall_r    <= irw_pkg::WALL_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        irw_pkg::REG_SENSOR_TYPE: styp_r    <= pwdata[0];
        irw_pkg::REG_MOUNT_X:     mnt_x_r   <= pwdata[17:0];
        irw_pkg::REG_MOUNT_Y:     mnt_y_r   <= pwdata[17:0];
        irw_pkg::REG_MOUNT_COS:   mnt_cos_r <= pwdata[15:0];
        irw_pkg::REG_MOUNT_SIN:   mnt_sin_r <= pwdata[15:0];
        irw_pkg::REG_WALL_LIMIT:  wall_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back, signed fields sign-extended
  always_comb begin
    unique case (cfg_idx)
      irw_pkg::REG_SENSOR_TYPE: prdata = {31'd0, styp_r};
      irw_pkg::REG_MOUNT_X:     prdata = {{14{mnt_x_r[17]}}, mnt_x_r};
      irw_pkg::REG_MOUNT_Y:     prdata = {{14{mnt_y_r[17]}}, mnt_y_r};
      irw_pkg::REG_MOUNT_COS:   prdata = {{16{mnt_cos_r[15]}}, mnt_cos_r};
      irw_pkg::REG_MOUNT_SIN:   prdata = {{16{mnt_sin_r[15]}}, mnt_sin_r};
      irw_pkg::REG_WALL_LIMIT:  prdata = {16'd0, wall_r};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // stage valid bits and per-stage advance
  // --------------------------------------------------------------------------
  logic [NumStg:1]   vld_r;
  logic [NumStg:1]   vld_nxt;
  logic [NumStg+1:1] adv;

  always_comb begin
    adv[NumStg+1] = out_ready;
    for (int k = NumStg; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign vld_nxt  = {vld_r[NumStg-1:1], in_valid};
  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NumStg; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // pose travels alongside the data up to the last stage
  irw_pkg::pose_t pose_r [1:NumStg-1];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pose_r[1] <= '{rx: in_data.robot_x, ry: in_data.robot_y,
                     rs: in_data.robot_sin, rc: in_data.robot_cos};
    end
    for (int k = 2; k <= NumStg - 1; k++) begin
      if (adv[k]) begin
        pose_r[k] <= pose_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: normalize sample, special cases, segment lookup, square
  // --------------------------------------------------------------------------
  logic [irw_pkg::ADC_BITS+SmpW-1:0] smp_wide;
  logic [SmpW-1:0]    smp;
  logic [1:0]         seg;
  logic               spec;
  logic [15:0]        spec_d;
  logic [SmpW-1:0]    s1_smp_r;
  logic [2*SmpW-1:0]  s1_sq_r;
  irw_pkg::coef_t     s1_cf_r;
  logic               s1_spec_r;
  logic [15:0]        s1_spec_d_r;

  assign smp_wide = {{SmpW{1'b0}}, in_data.adc_sample};
  assign smp = SmpW'((smp_wide >> irw_pkg::ADC_SHR) << irw_pkg::ADC_SHL);

  // fixed answers below and above the calibrated span
  always_comb begin
    spec   = 1'b0;
    spec_d = irw_pkg::DIST_MIN;
    if (!styp_r) begin
      if (smp < irw_pkg::LONG_LO) begin
        spec   = 1'b1;
        spec_d = irw_pkg::LONG_NEAR_D;
      end else if (smp > irw_pkg::LONG_HI) begin
        spec   = 1'b1;
        spec_d = irw_pkg::LONG_FAR_D;
      end
    end else begin
      if (smp < irw_pkg::SHORT_LO) begin
        spec   = 1'b1;
        spec_d = irw_pkg::SHORT_NEAR_D;
      end else if (smp > irw_pkg::SHORT_HI) begin
        spec   = 1'b1;
        spec_d = irw_pkg::SHORT_FAR_D;
      end
    end
  end

  // first segment whose breakpoint is not below the sample
  always_comb begin
    priority if (smp <= irw_pkg::seg_bound(styp_r, 2'd0)) seg = 2'd0;
    else if (smp <= irw_pkg::seg_bound(styp_r, 2'd1))     seg = 2'd1;
    else if (smp <= irw_pkg::seg_bound(styp_r, 2'd2))     seg = 2'd2;
    else                                                  seg = 2'd3;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_smp_r    <= smp;
      s1_sq_r     <= smp * smp;
      s1_cf_r     <= irw_pkg::coef_lookup(styp_r, seg);
      s1_spec_r   <= spec;
      s1_spec_d_r <= spec_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: quadratic and linear products
  // --------------------------------------------------------------------------
  logic signed [46:0] s2_pa_r;
  logic signed [45:0] s2_pb_r;
  logic signed [41:0] s2_c_r;
  logic               s2_spec_r;
  logic [15:0]        s2_spec_d_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_pa_r     <= s1_cf_r.a * $signed({1'b0, s1_sq_r});
      s2_pb_r     <= s1_cf_r.b * $signed({1'b0, s1_smp_r});
      s2_c_r      <= s1_cf_r.c;
      s2_spec_r   <= s1_spec_r;
      s2_spec_d_r <= s1_spec_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: curve sum
  // --------------------------------------------------------------------------
  logic [47:0] s3_sum_r;
  logic        s3_spec_r;
  logic [15:0] s3_spec_d_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_sum_r    <= {s2_pa_r[46], s2_pa_r} + {{2{s2_pb_r[45]}}, s2_pb_r}
                     + {{6{s2_c_r[41]}}, s2_c_r};
      s3_spec_r   <= s2_spec_r;
      s3_spec_d_r <= s2_spec_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: round to 16 fraction bits, clamp, wall limit
  // --------------------------------------------------------------------------
  logic [47:0] rnd_sum;
  logic [23:0] q;
  logic [15:0] d;
  logic [15:0] s4_d_r;
  logic [15:0] s4_dw_r;

  assign rnd_sum = {1'b0, s3_sum_r[46:0]} + 48'd8388608;
  assign q       = rnd_sum[47:24];

  always_comb begin
    priority if (s3_spec_r)                          d = s3_spec_d_r;
    else if (s3_sum_r[47] || (s3_sum_r == '0))       d = irw_pkg::DIST_MIN;
    else if (q < 24'(irw_pkg::DIST_MIN))             d = irw_pkg::DIST_MIN;
    else if (q > 24'(irw_pkg::DIST_MAX))             d = irw_pkg::DIST_MAX;
    else                                             d = q[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d_r  <= d;
      s4_dw_r <= (d > wall_r) ? wall_r : d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: distance times mount direction
  // --------------------------------------------------------------------------
  logic signed [32:0] s5_hc_r, s5_hs_r, s5_wc_r, s5_ws_r;
  logic [15:0]        s5_d_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_hc_r <= $signed({1'b0, s4_d_r}) * mnt_cos_r;
      s5_hs_r <= $signed({1'b0, s4_d_r}) * mnt_sin_r;
      s5_wc_r <= $signed({1'b0, s4_dw_r}) * mnt_cos_r;
      s5_ws_r <= $signed({1'b0, s4_dw_r}) * mnt_sin_r;
      s5_d_r  <= s4_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: round and add mount offset (robot frame point)
  // --------------------------------------------------------------------------
  function automatic logic signed [20:0] mount_add(input logic signed [32:0] p,
                                                   input logic signed [17:0] ofs);
    logic [33:0] r;
    r = {p[32], p} + 34'd8192;
    return {{3{ofs[17]}}, ofs} + {r[33], r[33:14]};
  endfunction

  logic signed [20:0] s6_phx_r, s6_phy_r, s6_pwx_r, s6_pwy_r;
  logic [15:0]        s6_d_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_phx_r <= mount_add(s5_hc_r, mnt_x_r);
      s6_phy_r <= mount_add(s5_hs_r, mnt_y_r);
      s6_pwx_r <= mount_add(s5_wc_r, mnt_x_r);
      s6_pwy_r <= mount_add(s5_ws_r, mnt_y_r);
      s6_d_r   <= s5_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: rotation products by robot heading
  // --------------------------------------------------------------------------
  logic signed [36:0] s7_hxc_r, s7_hys_r, s7_hxs_r, s7_hyc_r;
  logic signed [36:0] s7_wxc_r, s7_wys_r, s7_wxs_r, s7_wyc_r;
  logic [15:0]        s7_d_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_hxc_r <= s6_phx_r * pose_r[6].rc;
      s7_hys_r <= s6_phy_r * pose_r[6].rs;
      s7_hxs_r <= s6_phx_r * pose_r[6].rs;
      s7_hyc_r <= s6_phy_r * pose_r[6].rc;
      s7_wxc_r <= s6_pwx_r * pose_r[6].rc;
      s7_wys_r <= s6_pwy_r * pose_r[6].rs;
      s7_wxs_r <= s6_pwx_r * pose_r[6].rs;
      s7_wyc_r <= s6_pwy_r * pose_r[6].rc;
      s7_d_r   <= s6_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: combine and round rotation terms
  // --------------------------------------------------------------------------
  function automatic logic signed [24:0] rot_round(input logic signed [36:0] p,
                                                   input logic signed [36:0] m,
                                                   input logic               sub);
    logic [37:0] s;
    logic [38:0] r;
    s = sub ? ({p[36], p} - {m[36], m}) : ({p[36], p} + {m[36], m});
    r = {s[37], s} + 39'd8192;
    return r[38:14];
  endfunction

  logic signed [24:0] s8_hx_r, s8_hy_r, s8_wx_r, s8_wy_r;
  logic [15:0]        s8_d_r;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_hx_r <= rot_round(s7_hxc_r, s7_hys_r, 1'b1);
      s8_hy_r <= rot_round(s7_hxs_r, s7_hyc_r, 1'b0);
      s8_wx_r <= rot_round(s7_wxc_r, s7_wys_r, 1'b1);
      s8_wy_r <= rot_round(s7_wxs_r, s7_wyc_r, 1'b0);
      s8_d_r  <= s7_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: translate by robot position, saturate, output register
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] place_sat(input logic signed [31:0] base,
                                                   input logic signed [24:0] ofs);
    logic [33:0] s;
    logic signed [31:0] res;
    s = {{2{base[31]}}, base} + {{9{ofs[24]}}, ofs};
    if ((s[33:31] == 3'b000) || (s[33:31] == 3'b111)) begin
      res = s[31:0];
    end else if (s[33]) begin
      res = {1'b1, 31'd0};
    end else begin
      res = {1'b0, {31{1'b1}}};
    end
    return res;
  endfunction

  irw_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      out_r.range_m <= s8_d_r;
      out_r.hit_x   <= place_sat(pose_r[8].rx, s8_hx_r);
      out_r.hit_y   <= place_sat(pose_r[8].ry, s8_hy_r);
      out_r.wall_x  <= place_sat(pose_r[8].rx, s8_wx_r);
      out_r.wall_y  <= place_sat(pose_r[8].ry, s8_wy_r);
    end
  end

  assign out_valid = vld_r[NumStg];
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/irw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irw_checker
// Port-level checks for the infrared range to world point converter.
// ----------------------------------------------------------------------------
module irw_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire irw_pkg::out_t                out_data
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reported distance always inside the clamp window
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.range_m >= irw_pkg::DIST_MIN) &&
                  (out_data.range_m <= irw_pkg::DIST_MAX))
    else $error("range outside clamp window");

  // input back-pressure only comes from a stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output drains");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ir_range_to_world_point irw_checker u_irw_checker (.*);
`default_nettype wire

// ===== bench/ir_range_to_world_point_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_to_world_point_test
// Self-checking bench for the range sample to world point converter. A
// directed table walks span edges and segment breakpoints of both sensor
// tables and saturation corners of the long table, then random samples and
// poses run under changing mount settings and several handshake idling mixes.
// Each result is checked against a typed row or a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
module ir_range_to_world_point_test;

  localparam int     ADC_W       = irw_pkg::ADC_BITS;
  localparam int     HOLD_CYCLES = 300;
  localparam int     BLOCK_ITEMS = 100;
  localparam longint RANGE_FLOOR = 2621;
  localparam longint RANGE_CEIL  = 52429;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;
  // calibrated span edges; fixed answers outside them
  localparam int     LONG_LOW_EDGE  = 124;
  localparam int     LONG_HIGH_EDGE = 927;
  localparam int     SHORT_LOW_EDGE = 96;
  localparam int     SHORT_HIGH_EDGE = 853;

  typedef struct {
    bit            styp;
    irw_pkg::in_t  stim;
    bit            typed;
    irw_pkg::out_t want;
  } dir_row_t;

  typedef struct {
    bit            typed;
    irw_pkg::out_t want;
  } typed_want_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  irw_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  irw_pkg::out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [irw_pkg::PADDR_W-1:0] paddr;
  logic [irw_pkg::PDATA_W-1:0] pwdata;
  logic [irw_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // model copy of the registers
  bit     sensor_sel;
  longint mnt_x;
  longint mnt_y;
  longint mnt_cos;
  longint mnt_sin;
  longint wall_cap;

  irw_pkg::out_t pending_points[$];
  typed_want_t   directed_want_q[$];
  dir_row_t      dir_rows[$];
  int            mismatch_count;
  int            sender_idle_pct;
  int            recv_stall_pct;
  bit            hold_req;
  int            knee_samples [0:15] = '{95, 96, 123, 124, 233, 234, 334, 335,
                                         508, 509, 543, 544, 853, 854, 927, 928};

  ir_range_to_world_point i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("ir_range_to_world_point test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // fixed-point model
  // ---------------------------------------------------------------------------

  // upper breakpoint and Q.40 coefficients of one curve segment
  function automatic void curve_segment(input bit styp, input int seg,
                                        output longint bound, output longint ca,
                                        output longint cb, output longint cc);
    case ({styp, seg[1:0]})
      3'b000: begin
        bound = 233; ca = 21990233; cb = -64'sd11984676743; cc = 64'sd2027389490456;
      end
      3'b001: begin
        bound = 334; ca = 3298535; cb = -64'sd3628388372; cc = 64'sd1093134460335;
      end
      3'b010: begin
        bound = 508; ca = -439805; cb = -64'sd219902326; cc = 64'sd402080962743;
      end
      3'b011: begin
        bound = 853; ca = 219902; cb = -64'sd549755814; cc = 64'sd369545858096;
      end
      3'b100: begin
        bound = 124; ca = -21990233; cb = 64'sd1649267442; cc = 64'sd515561002264;
      end
      3'b101: begin
        bound = 334; ca = 3298535; cb = -64'sd2418925581; cc = 64'sd579772481326;
      end
      3'b110: begin
        bound = 543; ca = 549756; cb = -64'sd769658139; cc = 64'sd327544513914;
      end
      default: begin
        bound = 853; ca = 76966; cb = -64'sd219902326; cc = 64'sd171963618584;
      end
    endcase
  endfunction

  // 10-bit sample to clamped distance, 16 fraction bits
  function automatic logic [15:0] sample_to_range(input longint v);
    longint bound, ca, cb, cc, sum, q;
    int seg;
    if (!sensor_sel) begin
      if (v < LONG_LOW_EDGE) return 16'd52429;
      if (v > LONG_HIGH_EDGE) return 16'd6554;
    end else begin
      if (v < SHORT_LOW_EDGE) return 16'd19661;
      if (v > SHORT_HIGH_EDGE) return 16'd2621;
    end
    seg = 0;
    curve_segment(sensor_sel, seg, bound, ca, cb, cc);
    while (seg < 3 && v > bound) begin
      seg++;
      curve_segment(sensor_sel, seg, bound, ca, cb, cc);
    end
    sum = ca * v * v + cb * v + cc;
    if (sum <= 0) return RANGE_FLOOR[15:0];
    q = (sum + 64'sd8388608) >>> 24;
    if (q < RANGE_FLOOR) return RANGE_FLOOR[15:0];
    if (q > RANGE_CEIL) return RANGE_CEIL[15:0];
    return q[15:0];
  endfunction

  // Q14 product back to 16 fraction bits, round half up
  function automatic longint round_q14(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // sensor frame point at distance d, rotated and moved into the world
  function automatic void place_point(input longint d, input irw_pkg::in_t s,
                                      output logic [31:0] wx, output logic [31:0] wy);
    longint px, py, rx, ry, rs, rc;
    px = mnt_x + round_q14(d * mnt_cos);
    py = mnt_y + round_q14(d * mnt_sin);
    rx = longint'($signed(s.robot_x));
    ry = longint'($signed(s.robot_y));
    rs = longint'($signed(s.robot_sin));
    rc = longint'($signed(s.robot_cos));
    wx = 32'(clamp_s32(rx + round_q14(px * rc - py * rs)));
    wy = 32'(clamp_s32(ry + round_q14(px * rs + py * rc)));
  endfunction

  function automatic irw_pkg::out_t project_sample(input irw_pkg::in_t s);
    irw_pkg::out_t r;
    longint v, d, dw;
    logic [31:0] ax, ay, bx, by;
    if (ADC_W >= 10) v = longint'(s.adc_sample >> (ADC_W - 10));
    else v = longint'(s.adc_sample << (10 - ADC_W));
    v = v & 64'h3FF;
    d = longint'(sample_to_range(v));
    dw = (d > wall_cap) ? wall_cap : d;
    place_point(d, s, ax, ay);
    place_point(dw, s, bx, by);
    r.range_m = d[15:0];
    r.hit_x = ax;
    r.hit_y = ay;
    r.wall_x = bx;
    r.wall_y = by;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_point(input irw_pkg::out_t want, input irw_pkg::out_t got);
    if (got.range_m !== want.range_m)
      note_mismatch($sformatf("range_m expected %0d got %0d", want.range_m, got.range_m));
    if (got.hit_x !== want.hit_x)
      note_mismatch($sformatf("hit_x expected %0d got %0d",
                              $signed(want.hit_x), $signed(got.hit_x)));
    if (got.hit_y !== want.hit_y)
      note_mismatch($sformatf("hit_y expected %0d got %0d",
                              $signed(want.hit_y), $signed(got.hit_y)));
    if (got.wall_x !== want.wall_x)
      note_mismatch($sformatf("wall_x expected %0d got %0d",
                              $signed(want.wall_x), $signed(got.wall_x)));
    if (got.wall_y !== want.wall_y)
      note_mismatch($sformatf("wall_y expected %0d got %0d",
                              $signed(want.wall_y), $signed(got.wall_y)));
  endtask

  // predict on input transactions, check result transactions
  always @(posedge clk) begin
    typed_want_t   tw;
    irw_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = project_sample(in_data);
        if (directed_want_q.size() != 0) begin
          tw = directed_want_q.pop_front();
          if (tw.typed) want = tw.want;
        end
        pending_points.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          note_mismatch("result transaction with nothing expected");
        end else begin
          want = pending_points.pop_front();
          compare_point(want, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver
  // ---------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the pipeline fills and stalls its input
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and configuration
  // ---------------------------------------------------------------------------

  task automatic send_item(input irw_pkg::in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input irw_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      irw_pkg::REG_SENSOR_TYPE: sensor_sel = val[0];
      irw_pkg::REG_MOUNT_X:     mnt_x = longint'($signed(val[17:0]));
      irw_pkg::REG_MOUNT_Y:     mnt_y = longint'($signed(val[17:0]));
      irw_pkg::REG_MOUNT_COS:   mnt_cos = longint'($signed(val[15:0]));
      irw_pkg::REG_MOUNT_SIN:   mnt_sin = longint'($signed(val[15:0]));
      irw_pkg::REG_WALL_LIMIT:  wall_cap = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_q14();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF - $urandom_range(20'hF_FFFF);
      1: return 32'h8000_0000 + $urandom_range(20'hF_FFFF);
      2, 3: return $urandom_range(22'h3F_FFFF) - 32'h0020_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic irw_pkg::in_t random_item();
    irw_pkg::in_t it;
    if ($urandom_range(4) == 0) it.adc_sample = ADC_W'(knee_samples[$urandom_range(15)]);
    else it.adc_sample = ADC_W'($urandom_range((1 << ADC_W) - 1));
    it.robot_x   = random_coord();
    it.robot_y   = random_coord();
    it.robot_sin = random_q14();
    it.robot_cos = random_q14();
    return it;
  endfunction

  // one register setting: defaults, both extremes, or random
  task automatic apply_setup(input int mode);
    int styp, mx, my, mc, ms, wl;
    case (mode)
      0: begin
        styp = 0; mx = 0; my = 0; mc = 16384; ms = 0; wl = 22938;
      end
      1: begin
        styp = 1; mx = 65536; my = 65536; mc = 16384; ms = 16384; wl = 65535;
      end
      2: begin
        styp = 0; mx = -65536; my = -65536; mc = -16384; ms = -16384; wl = 0;
      end
      default: begin
        styp = $urandom_range(1);
        mx   = $urandom_range(131072) - 65536;
        my   = $urandom_range(131072) - 65536;
        mc   = $signed(random_q14());
        ms   = $signed(random_q14());
        wl   = $urandom_range(65535);
      end
    endcase
    write_reg(irw_pkg::REG_SENSOR_TYPE, styp);
    write_reg(irw_pkg::REG_MOUNT_X, mx);
    write_reg(irw_pkg::REG_MOUNT_Y, my);
    write_reg(irw_pkg::REG_MOUNT_COS, mc);
    write_reg(irw_pkg::REG_MOUNT_SIN, ms);
    write_reg(irw_pkg::REG_WALL_LIMIT, wl);
  endtask

  task automatic add_row(input bit styp, input int smp, input logic [31:0] rx,
                         input logic [31:0] ry, input logic [15:0] rs,
                         input logic [15:0] rc, input bit typed, input logic [15:0] rm,
                         input logic [31:0] hx, input logic [31:0] hy,
                         input logic [31:0] wx, input logic [31:0] wy);
    dir_row_t row;
    row.styp = styp;
    row.stim.adc_sample = ADC_W'(smp);
    row.stim.robot_x = rx;
    row.stim.robot_y = ry;
    row.stim.robot_sin = rs;
    row.stim.robot_cos = rc;
    row.typed = typed;
    row.want.range_m = rm;
    row.want.hit_x = hx;
    row.want.hit_y = hy;
    row.want.wall_x = wx;
    row.want.wall_y = wy;
    dir_rows.push_back(row);
  endtask

  // main sequence
  initial begin
    typed_want_t tw;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_data         <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    sensor_sel      = 1'b0;
    mnt_x           = 0;
    mnt_y           = 0;
    mnt_cos         = 16384;
    mnt_sin         = 0;
    wall_cap        = 22938;

    // directed table, register defaults apart from the sensor type
    // long table: span edges, breakpoints, saturation corners
    add_row(0, 0,    0, 0, 0, 16384, 1, 52429, 52429, 0, 22938, 0);
    add_row(0, 123,  0, 0, 0, 16384, 1, 52429, 52429, 0, 22938, 0);
    add_row(0, 124,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 233,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 234,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 334,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 508,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 853,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 927,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 928,  0, 0, 0, 16384, 1, 6554, 6554, 0, 6554, 0);
    add_row(0, 1023, 0, 0, 0, 16384, 1, 6554, 6554, 0, 6554, 0);
    add_row(0, 0, 32'h7FFF_FFFF, 0, 0, 16384, 1,
            52429, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0);
    add_row(0, 0, 32'h8000_0000, 32'h8000_0000, 0, -16'sd16384, 1,
            52429, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(0, 0, 0, 32'h7FFF_FFFF, 16384, 0, 1,
            52429, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    // short table
    add_row(1, 0,    0, 0, 0, 16384, 1, 19661, 19661, 0, 19661, 0);
    add_row(1, 95,   0, 0, 0, 16384, 1, 19661, 19661, 0, 19661, 0);
    add_row(1, 96,   0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(1, 124,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(1, 334,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(1, 543,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(1, 853,  0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(1, 854,  0, 0, 0, 16384, 1, 2621, 2621, 0, 2621, 0);
    add_row(1, 1023, 0, 0, 0, 16384, 1, 2621, 2621, 0, 2621, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].styp != sensor_sel) begin
        wait_for_results();
        write_reg(irw_pkg::REG_SENSOR_TYPE, 32'(dir_rows[i].styp));
      end
      tw.typed = dir_rows[i].typed;
      tw.want  = dir_rows[i].want;
      directed_want_q.push_back(tw);
      send_item(dir_rows[i].stim);
    end

    // random part: four idling mixes, five register settings each
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin sender_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        wait_for_results();
        apply_setup(blk);
        if (phase == 0 && blk == 3) hold_req = 1'b1;
        repeat (BLOCK_ITEMS) send_item(random_item());
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("ir_range_to_world_point test passed");
    end else begin
      $display("ir_range_to_world_point test failed");
    end
    $finish;
  end

endmodule
